[design/cfm_pkg.sv]
// ----------------------------------------------------------------------------
// Cassette FSK modem package
// Shared types and constants for the cassette FSK modem core.
// ----------------------------------------------------------------------------
package cfm_pkg;

   // Field widths.
   localparam int SAMPLE_W = 16;
   localparam int GAP_W    = 8;
   localparam int OUT_W    = 5;

   // Padded stream widths.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   // Configuration register indexes.
   localparam logic CSR_MODE      = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   // Speed modes.
   typedef enum logic [1:0] {
      MODE_SLOW     = 2'd0,
      MODE_FAST     = 2'd1,
      MODE_IDLE     = 2'd2,
      MODE_IDLE_ALT = 2'd3
   } mode_type;

   // Reset values of the configuration registers.
   localparam mode_type                    MODE_RESET      = MODE_IDLE_ALT;
   localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = 16'sd655;

   // Receive decision limits.
   localparam logic [GAP_W-1:0] SLOW_SHORT_LIMIT = 8'd6;
   localparam logic [GAP_W-1:0] FAST_SHORT_LIMIT = 8'd10;
   localparam logic [GAP_W-1:0] LONG_LIMIT       = 8'd32;
   localparam logic [GAP_W-1:0] GAP_MAX          = 8'hff;

   // Control handed from the pipeline to the receive and transmit units.
   typedef struct packed {
      logic advance;  // an item moves into the result register this cycle
      logic active;   // mode is slow or fast
      logic fast;     // mode is fast
   } ctrl_type;

endpackage

[design/cfm_rx_decode.sv]
// ----------------------------------------------------------------------------
// Cassette FSK receive decoder
// Thresholds the tape sample and decodes bits from the gap between edges.
// ----------------------------------------------------------------------------
module cfm_rx_decode (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cfm_pkg::ctrl_type                     ctrl,
   input  logic signed [cfm_pkg::SAMPLE_W-1:0]   sample,
   input  logic signed [cfm_pkg::SAMPLE_W-1:0]   threshold,
   output logic                                  rx_bit,
   output logic                                  rx_strobe
);

   logic [cfm_pkg::GAP_W-1:0] gap_ff, gap_in, gap_inc;
   logic                      last_ff, last_in;
   logic                      decoded_ff, decoded_in;
   logic                      level, changed, fire, short_gap;
   logic [cfm_pkg::GAP_W-1:0] limit;

   always_comb begin
      level     = (sample > threshold);
      gap_inc   = (gap_ff == cfm_pkg::GAP_MAX) ? gap_ff : gap_ff + 8'd1;
      changed   = (level != last_ff);
      fire      = changed || (ctrl.fast && (gap_inc == cfm_pkg::FAST_SHORT_LIMIT));
      limit     = ctrl.fast ? cfm_pkg::FAST_SHORT_LIMIT : cfm_pkg::SLOW_SHORT_LIMIT;
      short_gap = (gap_inc < limit) || (gap_inc > cfm_pkg::LONG_LIMIT);

      gap_in     = gap_ff;
      last_in    = last_ff;
      decoded_in = decoded_ff;
      rx_strobe  = 1'b0;
      if (ctrl.active) begin
         gap_in    = changed ? '0 : gap_inc;
         last_in   = changed ? level : last_ff;
         rx_strobe = fire;
         if (fire) begin
            decoded_in = short_gap;
         end
      end
      rx_bit = decoded_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff     <= '0;
         last_ff    <= 1'b0;
         decoded_ff <= 1'b1;
      end else if (ctrl.advance) begin
         gap_ff     <= gap_in;
         last_ff    <= last_in;
         decoded_ff <= decoded_in;
      end
   end

endmodule

[design/cfm_tx_encode.sv]
// ----------------------------------------------------------------------------
// Cassette FSK transmit encoder
// Samples the serial transmit bit and toggles the tape output level.
// ----------------------------------------------------------------------------
module cfm_tx_encode (
   input  logic              clock,
   input  logic              reset,
   input  cfm_pkg::ctrl_type ctrl,
   input  logic              tx_bit,
   output logic              tape_level,
   output logic              tape_toggled
);

   logic [cfm_pkg::OUT_W-1:0] count_ff, count_in, count_inc;
   logic                      held_ff, held_in;
   logic                      level_ff, level_in;
   logic                      at_sample, at_step, in_half;

   always_comb begin
      count_inc = count_ff + 5'd1;
      at_sample = ctrl.fast ? (count_inc[2:0] == 3'd0) : (count_inc == 5'd0);

      count_in = count_ff;
      held_in  = held_ff;
      level_in = level_ff;
      tape_toggled = 1'b0;
      if (ctrl.active) begin
         count_in = count_inc;
         if (at_sample && (tx_bit != held_ff)) begin
            held_in  = tx_bit;
            count_in = '0;
         end
         at_step = ctrl.fast ? (count_in[2:0] == 3'd0) : (count_in[1:0] == 2'd0);
         in_half = ctrl.fast ? count_in[3] : count_in[2];
         // A zero bit skips the toggles of its second half.
         tape_toggled = at_step && !(!held_in && in_half);
         level_in     = level_ff ^ tape_toggled;
      end else begin
         at_step = 1'b0;
         in_half = 1'b0;
      end
      tape_level = level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held_ff  <= 1'b0;
         level_ff <= 1'b1;
      end else if (ctrl.advance) begin
         count_ff <= count_in;
         held_ff  <= held_in;
         level_ff <= level_in;
      end
   end

endmodule

[design/cassette_fsk_modem_core.sv]
// ----------------------------------------------------------------------------
// Cassette FSK modem core
// Tick-driven tape modem: decodes tape edges into serial bits and encodes the
// serial transmit bit as a two-frequency tape output level.
// ----------------------------------------------------------------------------
// An accepted tick is held in the input register, then moves into the result
// register once that register is free, and its result transfers from there.
// Throughput: one tick per cycle while the output side is ready; the input and
// result registers form a two-stage pipeline; the decoders update on advance.
// Reset is synchronous and active high. It empties both stages, restores the
// mode (idle) and threshold (655) registers and the modem state.
// ----------------------------------------------------------------------------
module cassette_fsk_modem_core (
   input  logic                             clock,
   input  logic                             reset,
   // Input ticks.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: tape_sample[15:0], tx_serial_bit[16], zero pad[23:17].
   input  logic [cfm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Results.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: rx_bit[0], rx_strobe[1], tape_level[2],
   // tape_toggled[3], zero pad[7:4].
   output logic [cfm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration writes.
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [cfm_pkg::SAMPLE_W-1:0]     csr_wdata
);

   // Configuration registers.
   cfm_pkg::mode_type                     mode_ff;
   logic signed [cfm_pkg::SAMPLE_W-1:0]   threshold_ff;

   // Input stage.
   logic                                  in_valid_ff, in_valid_in;
   logic signed [cfm_pkg::SAMPLE_W-1:0]   in_sample_ff;
   logic                                  in_tx_ff;

   // Result stage.
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [3:0]                            rsp_fields_ff, rsp_fields_in;

   logic                                  req_accept, out_free;
   cfm_pkg::ctrl_type                     ctrl;
   logic                                  rx_bit, rx_strobe, tape_level, tape_toggled;

   // The user must write configuration only while the modem is idle (the block
   // itself does not enforce this), so the units read these registers directly.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= cfm_pkg::MODE_RESET;
         threshold_ff <= cfm_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            cfm_pkg::CSR_MODE:      mode_ff      <= cfm_pkg::mode_type'(csr_wdata[1:0]);
            cfm_pkg::CSR_THRESHOLD: threshold_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // The result register is free when empty or when its item transfers now.
   // An item in the input stage advances whenever the result register is free,
   // and that same cycle the input stage can take the next tick.
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      req_tready   = !reset && (!in_valid_ff || out_free);
      req_accept   = req_tvalid && req_tready;

      ctrl.advance = in_valid_ff && out_free;
      ctrl.active  = (mode_ff == cfm_pkg::MODE_SLOW) || (mode_ff == cfm_pkg::MODE_FAST);
      ctrl.fast    = (mode_ff == cfm_pkg::MODE_FAST);

      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (ctrl.advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      rsp_valid_in  = out_free ? in_valid_ff : rsp_valid_ff;
      rsp_fields_in = {tape_toggled, tape_level, rx_strobe, rx_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_sample_ff <= $signed(req_tdata[cfm_pkg::SAMPLE_W-1:0]);
         in_tx_ff     <= req_tdata[cfm_pkg::SAMPLE_W];
      end
      if (ctrl.advance) begin
         rsp_fields_ff <= rsp_fields_in;
      end
   end

   // Receive side: level threshold and edge-gap bit decision.
   cfm_rx_decode u_rx (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .sample    (in_sample_ff),
      .threshold (threshold_ff),
      .rx_bit    (rx_bit),
      .rx_strobe (rx_strobe)
   );

   // Transmit side: bit sampling and tape level toggling.
   cfm_tx_encode u_tx (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .tx_bit       (in_tx_ff),
      .tape_level   (tape_level),
      .tape_toggled (tape_toggled)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_fields_ff};

endmodule

[design/cfm_checker.sv]
// ----------------------------------------------------------------------------
// Cassette FSK modem port checker
// Concurrent checks on the core's ports, bound to the top level.
// ----------------------------------------------------------------------------
module cfm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [cfm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The input side never stalls while the output side is ready.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled with output ready");

   // A stalled result stays offered.
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload.
   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

bind cassette_fsk_modem_core cfm_checker u_cfm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
